// File: src/assert_macros.svh
// Assertion macros used by the convolution top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ikc_pkg.sv
// Types and constants shared by the image kernel convolution modules.
package ikc_pkg;

    localparam int COEF_DIM = 5;
    localparam int COEF_W   = 12;
    localparam int PIX_W    = 8;
    localparam int VAL_W    = 16;
    localparam int CFG_W    = 60;
    localparam int IDX_W    = 3;
    localparam int KS_W     = 3;
    localparam int GEO_W    = 11;
    localparam int HALF_W   = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_KERNEL_SIZE,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_COEF_ROW0,
        REG_COEF_ROW1,
        REG_COEF_ROW2,
        REG_COEF_ROW3,
        REG_COEF_ROW4
    } reg_idx_t;

    localparam logic [KS_W-1:0]  KS_RESET     = 3'd1;
    localparam logic [GEO_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [GEO_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_W-1:0] COEF0_RESET  = 60'd256;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    // Per-item control that travels down the pipeline
    typedef struct packed {
        logic                emit;
        logic                frame_end;
        logic [COEF_DIM-1:0] row_ok;
        logic [COEF_DIM-1:0] col_ok;
    } ctl_t;

endpackage

// File: src/ikc_line_buf.sv
// Row history memories and the stage that assembles one window column.
module ikc_line_buf #(
    parameter int KL        = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ld,
    output logic                ld_ready,
    input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
    input  logic [((KL > 1) ? $clog2(KL) : 1)-1:0] wslot,
    input  ikc_pkg::pix_t       pix,
    input  ikc_pkg::ctl_t       ctl,
    input  ikc_pkg::coef_t      coef [KL][KL],
    output logic                col_valid,
    input  logic                col_ready,
    output ikc_pkg::pix_t       col [KL],
    output ikc_pkg::ctl_t       col_ctl,
    output ikc_pkg::coef_t      col_coef [KL][KL]
);
    import ikc_pkg::*;

    localparam int SW = (KL > 1) ? $clog2(KL) : 1;

    logic           v_reg;
    pix_t           pix_reg;
    logic [SW-1:0]  slot_reg;
    ctl_t           ctl_reg;
    coef_t          coef_reg [KL][KL];
    pix_t           rd_col [KL];

    assign ld_ready = !v_reg || col_ready;

    // One memory per row slot: write the current row, read all at the same column
    for (genvar s = 0; s < KL; s++) begin : g_slot
        pix_t mem [MAX_WIDTH];
        pix_t rd_reg;

        always_ff @(posedge clk)
        begin
            if (ld)
            begin
                if (wslot == SW'(s))
                begin
                    mem[waddr] <= pix;
                end
                rd_reg <= mem[waddr];
            end
        end

        assign rd_col[s] = rd_reg;
    end

    // Hold stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ld_ready)
        begin
            v_reg <= ld;
        end
    end

    // Capture beat payload
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            pix_reg  <= pix;
            slot_reg <= wslot;
            ctl_reg  <= ctl;
            coef_reg <= coef;
        end
    end

    // Order the column by row age, newest row first
    always_comb
    begin
        logic [SW-1:0] idx;
        idx    = '0;
        col[0] = pix_reg;
        for (int b = 1; b < KL; b++)
        begin
            if (slot_reg >= SW'(b))
            begin
                idx = slot_reg - SW'(b);
            end
            else
            begin
                idx = slot_reg + SW'(KL - b);
            end
            col[b] = rd_col[idx];
        end
    end

    assign col_valid = v_reg;
    assign col_ctl   = ctl_reg;
    assign col_coef  = coef_reg;

endmodule

// File: src/ikc_window.sv
// Sliding KLxKL pixel window, shifted by one column per beat.
module ikc_window #(
    parameter int KL = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ikc_pkg::pix_t  col [KL],
    input  ikc_pkg::ctl_t  in_ctl,
    input  ikc_pkg::coef_t in_coef [KL][KL],
    output logic           out_valid,
    input  logic           out_ready,
    output ikc_pkg::pix_t  win [KL][KL],
    output ikc_pkg::ctl_t  out_ctl,
    output ikc_pkg::coef_t out_coef [KL][KL]
);
    import ikc_pkg::*;

    logic   v_reg;
    logic   ld;
    pix_t   win_reg [KL][KL];
    ctl_t   ctl_reg;
    coef_t  coef_reg [KL][KL];

    // Items without a result leave the window stage without waiting
    assign in_ready = !v_reg || !ctl_reg.emit || out_ready;
    assign ld       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    // Shift the window left by one column
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            for (int b = 0; b < KL; b++)
            begin
                win_reg[b][0] <= col[b];
                for (int a = 1; a < KL; a++)
                begin
                    win_reg[b][a] <= win_reg[b][a-1];
                end
            end
            ctl_reg  <= in_ctl;
            coef_reg <= in_coef;
        end
    end

    assign out_valid = v_reg && ctl_reg.emit;
    assign win       = win_reg;
    assign out_ctl   = ctl_reg;
    assign out_coef  = coef_reg;

endmodule

// File: src/ikc_mac.sv
// Multiply, row sums, final sum with rounding and saturation, result register.
module ikc_mac #(
    parameter int KL = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ikc_pkg::pix_t                      win [KL][KL],
    input  ikc_pkg::ctl_t                      in_ctl,
    input  ikc_pkg::coef_t                     in_coef [KL][KL],
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ikc_pkg::VAL_W-1:0]   value,
    output logic                               frame_end
);
    import ikc_pkg::*;

    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ROW_W  = PROD_W + 3;
    localparam int TOT_W  = ROW_W + 3;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ROW_W-1:0]  row_t;

    logic   v3_reg, v4_reg, v5_reg;
    logic   fe3_reg, fe4_reg, fe5_reg;
    logic   rdy3, rdy4, rdy5;
    prod_t  prod [KL][KL];
    prod_t  p3_reg [KL][KL];
    row_t   rs [KL];
    row_t   rs4_reg [KL];
    logic signed [VAL_W-1:0] val_next;
    logic signed [VAL_W-1:0] val_reg;

    assign rdy5     = !v5_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    // Form masked products
    always_comb
    begin
        for (int b = 0; b < KL; b++)
        begin
            for (int a = 0; a < KL; a++)
            begin
                if (in_ctl.row_ok[b] && in_ctl.col_ok[a])
                begin
                    prod[b][a] = PROD_W'($signed({1'b0, win[b][a]})) * PROD_W'(in_coef[b][a]);
                end
                else
                begin
                    prod[b][a] = '0;
                end
            end
        end
    end

    // Sum each window row
    always_comb
    begin
        for (int b = 0; b < KL; b++)
        begin
            rs[b] = '0;
            for (int a = 0; a < KL; a++)
            begin
                rs[b] = rs[b] + ROW_W'(p3_reg[b][a]);
            end
        end
    end

    // Add rows, add one half, truncate toward zero, saturate
    always_comb
    begin
        logic signed [TOT_W-1:0] tot;
        logic signed [TOT_W-1:0] q;
        tot = '0;
        for (int b = 0; b < KL; b++)
        begin
            tot = tot + TOT_W'(rs4_reg[b]);
        end
        tot = tot + TOT_W'(128);
        q   = (tot + (tot[TOT_W-1] ? TOT_W'(255) : TOT_W'(0))) >>> 8;
        if (q > TOT_W'(32767))
        begin
            val_next = 16'sh7FFF;
        end
        else if (q < TOT_W'(-32768))
        begin
            val_next = 16'sh8000;
        end
        else
        begin
            val_next = VAL_W'(q);
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= in_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && rdy3)
        begin
            p3_reg  <= prod;
            fe3_reg <= in_ctl.frame_end;
        end
        if (v3_reg && rdy4)
        begin
            rs4_reg <= rs;
            fe4_reg <= fe3_reg;
        end
        if (v4_reg && rdy5)
        begin
            val_reg <= val_next;
            fe5_reg <= fe4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign value     = val_reg;
    assign frame_end = fe5_reg;

endmodule

// File: src/image_kernel_convolution_top.sv
// Top level of the streaming 2-D convolution with zero padding.
// Pixels enter in raster order, one beat per clock when nothing stalls; the result
// pipeline is five registers deep (line memory read, window, products, row sums,
// result), the first of them loaded by the accepting edge, and the block sustains
// one item per cycle when nothing stalls. The first result of a frame needs
// half*width + half beats first (half = (kernel_size-1)/2); kind 1 beats drain the
// tail. Kernel size, geometry and coefficients are sampled on the first pixel of a
// frame. Line memories are not cleared: rows outside the frame are masked instead.
`include "assert_macros.svh"

module image_kernel_convolution_top #(
    parameter int KERNEL_MAX = 5,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  ikc_pkg::pix_t                    pixel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [ikc_pkg::VAL_W-1:0] value,
    output logic                             frame_end,
    input  logic                             cfg_write,
    input  logic [ikc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [ikc_pkg::CFG_W-1:0]        cfg_data
);
    import ikc_pkg::*;

    localparam int KL  = (KERNEL_MAX < COEF_DIM) ? KERNEL_MAX : COEF_DIM;
    localparam int SW  = (KL > 1) ? $clog2(KL) : 1;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = CW + 1;
    localparam int RIW = $clog2(MAX_HEIGHT);
    localparam int HW  = RIW + 1;
    localparam int LW  = $clog2(2 * MAX_WIDTH + 3);
    localparam int RTW = HW + 1;
    localparam int CTW = WW + 1;

    // Configuration registers
    logic [KS_W-1:0]  ks_reg;
    logic [GEO_W-1:0] w_reg;
    logic [GEO_W-1:0] h_reg;
    logic [CFG_W-1:0] coef_reg [COEF_DIM];

    // Frame settings sampled at frame start
    logic [WW-1:0]     f_w_reg;
    logic [HW-1:0]     f_h_reg;
    logic [HALF_W-1:0] f_half_reg;
    coef_t             f_coef_reg [KL][KL];

    // Raster counters
    logic           busy_reg, busy_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [LW-1:0]  pre_reg, pre_next;
    logic [RIW-1:0] orow_reg, orow_next;
    logic [CW-1:0]  ocol_reg, ocol_next;

    logic [WW-1:0]     w_f, w_e;
    logic [HW-1:0]     h_f, h_e;
    logic [HALF_W-1:0] half_f, half_e;
    coef_t             cf_f [KL][KL];
    coef_t             cf_e [KL][KL];
    logic [LW-1:0]     lag_e;

    logic  lb_ready, take, emit, fe;
    ctl_t  s0_ctl;
    pix_t  pix_w;

    logic  col_valid, col_ready;
    pix_t  col [KL];
    ctl_t  col_ctl;
    coef_t col_coef [KL][KL];

    logic  win_valid, win_ready;
    pix_t  win [KL][KL];
    ctl_t  win_ctl;
    coef_t win_coef [KL][KL];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_reg <= KS_RESET;
            w_reg  <= WIDTH_RESET;
            h_reg  <= HEIGHT_RESET;
            for (int r = 0; r < COEF_DIM; r++)
            begin
                coef_reg[r] <= (r == 0) ? COEF0_RESET : '0;
            end
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KERNEL_SIZE:  ks_reg      <= cfg_data[KS_W-1:0];
                REG_IMAGE_WIDTH:  w_reg       <= cfg_data[GEO_W-1:0];
                REG_IMAGE_HEIGHT: h_reg       <= cfg_data[GEO_W-1:0];
                REG_COEF_ROW0:    coef_reg[0] <= cfg_data;
                REG_COEF_ROW1:    coef_reg[1] <= cfg_data;
                REG_COEF_ROW2:    coef_reg[2] <= cfg_data;
                REG_COEF_ROW3:    coef_reg[3] <= cfg_data;
                REG_COEF_ROW4:    coef_reg[4] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp geometry and kernel size, align coefficients to window ages
    always_comb
    begin
        logic [KS_W-1:0] k;
        logic [2:0]      kr;
        logic [2:0]      kc;
        coef_t           craw [COEF_DIM][COEF_DIM];
        if (w_reg == '0)
        begin
            w_f = WW'(1);
        end
        else if (int'(w_reg) > MAX_WIDTH)
        begin
            w_f = WW'(MAX_WIDTH);
        end
        else
        begin
            w_f = WW'(w_reg);
        end
        if (h_reg == '0)
        begin
            h_f = HW'(1);
        end
        else if (int'(h_reg) > MAX_HEIGHT)
        begin
            h_f = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_f = HW'(h_reg);
        end
        k = ks_reg;
        if (int'(k) > KL)
        begin
            k = KS_W'(KL);
        end
        if (k == '0)
        begin
            k = KS_W'(1);
        end
        if (!k[0])
        begin
            k = k - KS_W'(1);
        end
        half_f = HALF_W'(k >> 1);
        for (int r = 0; r < COEF_DIM; r++)
        begin
            for (int c = 0; c < COEF_DIM; c++)
            begin
                craw[r][c] = coef_t'(coef_reg[r][COEF_W*c +: COEF_W]);
            end
        end
        for (int b = 0; b < KL; b++)
        begin
            for (int a = 0; a < KL; a++)
            begin
                kr = {half_f, 1'b0} - 3'(b);
                kc = {half_f, 1'b0} - 3'(a);
                if (b <= int'({half_f, 1'b0}) && a <= int'({half_f, 1'b0}))
                begin
                    cf_f[b][a] = craw[kr][kc];
                end
                else
                begin
                    cf_f[b][a] = '0;
                end
            end
        end
    end

    // Use fresh settings on the first beat of a frame
    always_comb
    begin
        w_e    = busy_reg ? f_w_reg : w_f;
        h_e    = busy_reg ? f_h_reg : h_f;
        half_e = busy_reg ? f_half_reg : half_f;
        if (busy_reg)
        begin
            cf_e = f_coef_reg;
        end
        else
        begin
            cf_e = cf_f;
        end
        lag_e  = (half_e[1] ? (LW'(w_e) << 1) : (half_e[0] ? LW'(w_e) : '0)) + LW'(half_e);
    end

    assign in_stall = !lb_ready;
    assign take     = in_valid && lb_ready && !(!busy_reg && kind);
    assign emit     = (pre_reg >= lag_e);
    assign fe       = emit && ({1'b0, orow_reg} == h_e - HW'(1))
                           && ({1'b0, ocol_reg} == w_e - WW'(1));
    assign pix_w    = kind ? '0 : pixel;

    // Zero-padding masks by window row and column age
    always_comb
    begin
        logic [RTW-1:0] rt;
        logic [CTW-1:0] ct;
        rt = RTW'(orow_reg) + RTW'(half_e);
        ct = CTW'(ocol_reg) + CTW'(half_e);
        s0_ctl.emit      = emit;
        s0_ctl.frame_end = fe;
        for (int b = 0; b < COEF_DIM; b++)
        begin
            s0_ctl.row_ok[b] = (b < KL) && (b <= int'({half_e, 1'b0}))
                               && (rt >= RTW'(b)) && ((rt - RTW'(b)) < RTW'(h_e));
            s0_ctl.col_ok[b] = (b < KL) && (b <= int'({half_e, 1'b0}))
                               && (ct >= CTW'(b)) && ((ct - CTW'(b)) < CTW'(w_e));
        end
    end

    // Advance raster counters
    always_comb
    begin
        busy_next   = busy_reg;
        in_col_next = in_col_reg;
        slot_next   = slot_reg;
        pre_next    = pre_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        if (take)
        begin
            busy_next = 1'b1;
            if (({1'b0, in_col_reg} + WW'(1)) >= w_e)
            begin
                in_col_next = '0;
                slot_next   = (slot_reg == SW'(KL - 1)) ? '0 : slot_reg + SW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (!emit)
            begin
                pre_next = pre_reg + LW'(1);
            end
            else if (fe)
            begin
                busy_next   = 1'b0;
                in_col_next = '0;
                slot_next   = '0;
                pre_next    = '0;
                orow_next   = '0;
                ocol_next   = '0;
            end
            else if (({1'b0, ocol_reg} + WW'(1)) >= w_e)
            begin
                ocol_next = '0;
                orow_next = orow_reg + RIW'(1);
            end
            else
            begin
                ocol_next = ocol_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            in_col_reg <= '0;
            slot_reg   <= '0;
            pre_reg    <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            in_col_reg <= in_col_next;
            slot_reg   <= slot_next;
            pre_reg    <= pre_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
        end
    end

    // Latch frame settings on the first beat
    always_ff @(posedge clk)
    begin
        if (take && !busy_reg)
        begin
            f_w_reg    <= w_f;
            f_h_reg    <= h_f;
            f_half_reg <= half_f;
            f_coef_reg <= cf_f;
        end
    end

    ikc_line_buf #(
        .KL        (KL),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (take),
        .ld_ready  (lb_ready),
        .waddr     (in_col_reg),
        .wslot     (slot_reg),
        .pix       (pix_w),
        .ctl       (s0_ctl),
        .coef      (cf_e),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col       (col),
        .col_ctl   (col_ctl),
        .col_coef  (col_coef)
    );

    ikc_window #(
        .KL (KL)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (col_valid),
        .in_ready  (col_ready),
        .col       (col),
        .in_ctl    (col_ctl),
        .in_coef   (col_coef),
        .out_valid (win_valid),
        .out_ready (win_ready),
        .win       (win),
        .out_ctl   (win_ctl),
        .out_coef  (win_coef)
    );

    ikc_mac #(
        .KL (KL)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .win       (win),
        .in_ctl    (win_ctl),
        .in_coef   (win_coef),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .frame_end (frame_end)
    );

    `ASSERT_NEXT(a_frame_end_idles, take && fe, !busy_reg, "frame end did not close the frame")
    `ASSERT_ALWAYS(a_out_col_range, !busy_reg || ({1'b0, ocol_reg} < f_w_reg), "output column past width")
    `ASSERT_ALWAYS(a_lead_bounded, !busy_reg || (pre_reg <= lag_e), "lead count past lag")

endmodule
